FILE: hw/rtl/sctg_pkg.sv
// ----------------------------------------------------------------------------
// sctg_pkg
// Shared types, constants and the sine table generator of the tone generator.
// ----------------------------------------------------------------------------
package sctg_pkg;

	localparam int SAMPLE_RATE_DEF = 16000;
	localparam int FRAMES_DEF      = 320;
	localparam int SINE_POINTS_DEF = 1024;

	localparam int PHASE_W = 14;
	localparam int FRAME_W = 9;
	localparam int AMP_W   = 15;
	localparam int NOTE_W  = 13;
	localparam int MAG_W   = 15;
	localparam int SEL_W   = 2;
	localparam int NOTES   = 4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	localparam int PADDR_W = 5;
	localparam int DATA_W  = 32;

	localparam logic [2:0] REG_AMPLITUDE = 3'd0;
	localparam logic [2:0] REG_NOTE0     = 3'd1;
	localparam logic [2:0] REG_NOTE1     = 3'd2;
	localparam logic [2:0] REG_NOTE2     = 3'd3;
	localparam logic [2:0] REG_NOTE3     = 3'd4;

	localparam logic [AMP_W-1:0]  AMP_RST   = 15'd6000;
	localparam logic [NOTE_W-1:0] NOTE0_RST = 13'd400;
	localparam logic [NOTE_W-1:0] NOTE1_RST = 13'd600;
	localparam logic [NOTE_W-1:0] NOTE2_RST = 13'd800;
	localparam logic [NOTE_W-1:0] NOTE3_RST = 13'd1000;

	localparam logic [7:0] CH_NOTE_FIRST = 8'h31;
	localparam logic [7:0] CH_NOTE_LAST  = 8'h34;
	localparam logic [7:0] CH_PLAY       = 8'h70;
	localparam logic [7:0] CH_STOP       = 8'h73;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam int          TAYLOR_TERMS = 12;

	typedef struct packed {
		logic             sv;
		logic             amp_en;
		logic [SEL_W-1:0] note;
	} info_t;

	typedef struct packed {
		info_t              info;
		logic [PHASE_W-1:0] phase;
	} q_item_t;

	// Q30 Taylor series of sin(x), rounded to unsigned Q0.15
	function automatic logic [MAG_W-1:0] quarter_q15(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rnd;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > Q30_ONE) begin
			sum = Q30_ONE;
		end
		rnd = (sum * 64'd32767 + 64'd536870912) >> 30;
		return rnd[MAG_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/serial_controlled_tone_generator_top.sv
// ----------------------------------------------------------------------------
// serial_controlled_tone_generator_top
// Sine tone generator driven by command bytes and sample ticks.
// ----------------------------------------------------------------------------
// Input words: s_tuser = 0 carries a command byte in s_tdata ('1'..'4' pick
// a note and restart the wave, 'p' starts playback, 's' stops); s_tuser = 1
// is one sample tick. Every accepted word yields exactly one output word:
// m_tdata holds the sample, amplifier enable and current note, m_tuser marks
// a played sample. Amplitude and the four note frequencies sit behind the
// APB port at byte addresses 0, 4, 8, 12 and 16; write them only when idle,
// which the block does not enforce. One word per cycle is sustained while
// m_tready is high. A decoder updates play state and phase in the accept
// cycle and feeds a four-word queue; a seven-stage sine pipeline drains it
// (reciprocal index, correction, quadrant fold, quarter-wave table read,
// amplitude multiply, sign and output register). An output word not taken
// holds the pipeline, the queue fills and s_tready drops once four words
// wait. Reset empties the pipeline and queue, selects note 0, starts in the
// playing state at phase and frame 0, and loads the register reset values.
// ----------------------------------------------------------------------------
module serial_controlled_tone_generator_top #(
	parameter int SAMPLE_RATE = sctg_pkg::SAMPLE_RATE_DEF,
	parameter int FRAMES      = sctg_pkg::FRAMES_DEF,
	parameter int SINE_POINTS = sctg_pkg::SINE_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // cmd_byte[7:0]
	input  logic                          s_tuser,   // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // sample[15:0], amp_enable, note_now[1:0]
	output logic                          m_tuser,   // sample_valid
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sctg_pkg::PADDR_W-1:0]  paddr,
	input  logic [sctg_pkg::DATA_W-1:0]   pwdata,
	output logic [sctg_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [sctg_pkg::AMP_W-1:0]                          amplitude;
	logic [sctg_pkg::NOTES-1:0][sctg_pkg::PHASE_W-1:0]   note_step;
	logic                                                q_full;
	logic                                                q_empty;
	logic                                                q_push;
	logic                                                q_pop;
	sctg_pkg::q_item_t                                   q_wdata;
	sctg_pkg::q_item_t                                   q_rdata;

	assign pready = 1'b1;

	sctg_cfg #(
		.SAMPLE_RATE(SAMPLE_RATE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.amplitude (amplitude),
		.note_step (note_step)
	);

	sctg_front #(
		.SAMPLE_RATE(SAMPLE_RATE),
		.FRAMES     (FRAMES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.note_step (note_step),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	sctg_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	sctg_back #(
		.SAMPLE_RATE(SAMPLE_RATE),
		.SINE_POINTS(SINE_POINTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.amplitude (amplitude),
		.q_rdata   (q_rdata),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

FILE: hw/rtl/sctg_cfg.sv
// ----------------------------------------------------------------------------
// sctg_cfg
// Register file: amplitude and note frequencies, with the notes also kept
// reduced modulo the sample rate for the phase accumulator.
// ----------------------------------------------------------------------------
module sctg_cfg #(
	parameter int SAMPLE_RATE = sctg_pkg::SAMPLE_RATE_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               psel,
	input  logic                                               penable,
	input  logic                                               pwrite,
	input  logic [sctg_pkg::PADDR_W-1:0]                       paddr,
	input  logic [sctg_pkg::DATA_W-1:0]                        pwdata,
	output logic [sctg_pkg::DATA_W-1:0]                        prdata,
	output logic [sctg_pkg::AMP_W-1:0]                         amplitude,
	output logic [sctg_pkg::NOTES-1:0][sctg_pkg::PHASE_W-1:0]  note_step
);

	localparam int NSTEP = ((1 << sctg_pkg::NOTE_W) - 1) / SAMPLE_RATE;
	localparam int RW    = sctg_pkg::PHASE_W + 1;

	logic [sctg_pkg::AMP_W-1:0]                          amp_q;
	logic [sctg_pkg::NOTES-1:0][sctg_pkg::NOTE_W-1:0]    note_q;
	logic [sctg_pkg::NOTES-1:0][sctg_pkg::PHASE_W-1:0]   nred_q;
	logic [2:0]                                          idx;
	logic                                                wr;

	// at most (2**13-1)/SAMPLE_RATE conditional subtractions for a 13-bit value
	function automatic logic [sctg_pkg::PHASE_W-1:0] reduce(
		input logic [sctg_pkg::NOTE_W-1:0] v
	);
		logic [RW-1:0] r;
		r = RW'(v);
		for (int i = 0; i < NSTEP; i++) begin
			if (r >= RW'(SAMPLE_RATE)) begin
				r = r - RW'(SAMPLE_RATE);
			end
		end
		return r[sctg_pkg::PHASE_W-1:0];
	endfunction

	assign idx = paddr[4:2];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q     <= sctg_pkg::AMP_RST;
			note_q[0] <= sctg_pkg::NOTE0_RST;
			note_q[1] <= sctg_pkg::NOTE1_RST;
			note_q[2] <= sctg_pkg::NOTE2_RST;
			note_q[3] <= sctg_pkg::NOTE3_RST;
			nred_q[0] <= reduce(sctg_pkg::NOTE0_RST);
			nred_q[1] <= reduce(sctg_pkg::NOTE1_RST);
			nred_q[2] <= reduce(sctg_pkg::NOTE2_RST);
			nred_q[3] <= reduce(sctg_pkg::NOTE3_RST);
		end else if (wr) begin
			unique case (idx)
				sctg_pkg::REG_AMPLITUDE: begin
					amp_q <= pwdata[sctg_pkg::AMP_W-1:0];
				end
				sctg_pkg::REG_NOTE0: begin
					note_q[0] <= pwdata[sctg_pkg::NOTE_W-1:0];
					nred_q[0] <= reduce(pwdata[sctg_pkg::NOTE_W-1:0]);
				end
				sctg_pkg::REG_NOTE1: begin
					note_q[1] <= pwdata[sctg_pkg::NOTE_W-1:0];
					nred_q[1] <= reduce(pwdata[sctg_pkg::NOTE_W-1:0]);
				end
				sctg_pkg::REG_NOTE2: begin
					note_q[2] <= pwdata[sctg_pkg::NOTE_W-1:0];
					nred_q[2] <= reduce(pwdata[sctg_pkg::NOTE_W-1:0]);
				end
				sctg_pkg::REG_NOTE3: begin
					note_q[3] <= pwdata[sctg_pkg::NOTE_W-1:0];
					nred_q[3] <= reduce(pwdata[sctg_pkg::NOTE_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sctg_pkg::REG_AMPLITUDE: prdata = sctg_pkg::DATA_W'(amp_q);
			sctg_pkg::REG_NOTE0:     prdata = sctg_pkg::DATA_W'(note_q[0]);
			sctg_pkg::REG_NOTE1:     prdata = sctg_pkg::DATA_W'(note_q[1]);
			sctg_pkg::REG_NOTE2:     prdata = sctg_pkg::DATA_W'(note_q[2]);
			sctg_pkg::REG_NOTE3:     prdata = sctg_pkg::DATA_W'(note_q[3]);
			default:                 prdata = '0;
		endcase
	end

	assign amplitude = amp_q;
	assign note_step = nred_q;

endmodule

FILE: hw/rtl/sctg_front.sv
// ----------------------------------------------------------------------------
// sctg_front
// Input side: decodes command bytes and ticks, keeps play state, note,
// frame counter and phase, and queues one word per accepted item.
// ----------------------------------------------------------------------------
module sctg_front #(
	parameter int SAMPLE_RATE = sctg_pkg::SAMPLE_RATE_DEF,
	parameter int FRAMES      = sctg_pkg::FRAMES_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               s_tvalid,
	output logic                                               s_tready,
	input  logic [7:0]                                         s_tdata,
	input  logic                                               s_tuser,
	input  logic [sctg_pkg::NOTES-1:0][sctg_pkg::PHASE_W-1:0]  note_step,
	input  logic                                               q_full,
	output logic                                               q_push,
	output sctg_pkg::q_item_t                                  q_wdata
);

	localparam int SW = sctg_pkg::PHASE_W + 1;

	logic                             play_q;
	logic [sctg_pkg::SEL_W-1:0]       note_q;
	logic [sctg_pkg::FRAME_W-1:0]     frame_q;
	logic [sctg_pkg::PHASE_W-1:0]     phase_q;

	logic                             play_n;
	logic [sctg_pkg::SEL_W-1:0]       note_n;
	logic [sctg_pkg::FRAME_W-1:0]     frame_n;
	logic [sctg_pkg::PHASE_W-1:0]     phase_n;
	logic                             sv;
	logic [SW-1:0]                    psum;
	logic [SW-1:0]                    pwrap;
	logic [sctg_pkg::FRAME_W-1:0]     finc;
	logic [7:0]                       note_ofs;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	assign psum     = SW'(phase_q) + SW'(note_step[note_q]);
	assign pwrap    = (psum >= SW'(SAMPLE_RATE)) ? psum - SW'(SAMPLE_RATE) : psum;
	assign finc     = frame_q + sctg_pkg::FRAME_W'(1);
	assign note_ofs = s_tdata - sctg_pkg::CH_NOTE_FIRST;

	always_comb begin
		play_n  = play_q;
		note_n  = note_q;
		frame_n = frame_q;
		phase_n = phase_q;
		sv      = 1'b0;
		if (!s_tuser) begin
			priority if (s_tdata >= sctg_pkg::CH_NOTE_FIRST
					&& s_tdata <= sctg_pkg::CH_NOTE_LAST) begin
				note_n  = note_ofs[sctg_pkg::SEL_W-1:0];
				frame_n = '0;
				phase_n = '0;
			end else if (s_tdata == sctg_pkg::CH_PLAY) begin
				if (!play_q) begin
					play_n  = 1'b1;
					frame_n = '0;
					phase_n = '0;
				end
			end else if (s_tdata == sctg_pkg::CH_STOP) begin
				play_n = 1'b0;
			end else begin
			end
		end else if (play_q) begin
			sv = 1'b1;
			if (finc >= sctg_pkg::FRAME_W'(FRAMES)) begin
				frame_n = '0;
				phase_n = '0;
			end else begin
				frame_n = finc;
				phase_n = pwrap[sctg_pkg::PHASE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q  <= 1'b1;
			note_q  <= '0;
			frame_q <= '0;
			phase_q <= '0;
		end else if (q_push) begin
			play_q  <= play_n;
			note_q  <= note_n;
			frame_q <= frame_n;
			phase_q <= phase_n;
		end
	end

	// sample uses the phase before the advance
	assign q_wdata.info.sv     = sv;
	assign q_wdata.info.amp_en = play_n;
	assign q_wdata.info.note   = note_n;
	assign q_wdata.phase       = phase_q;

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < SAMPLE_RATE) else $error("phase out of range");
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q < FRAMES) else $error("frame counter out of range");
`endif

endmodule

FILE: hw/rtl/sctg_fifo.sv
// ----------------------------------------------------------------------------
// sctg_fifo
// Four-word queue between the decoder and the sine pipeline.
// ----------------------------------------------------------------------------
module sctg_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sctg_pkg::q_item_t wdata,
	input  logic              pop,
	output sctg_pkg::q_item_t rdata,
	output logic              full,
	output logic              empty
);

	sctg_pkg::q_item_t                 mem_q [sctg_pkg::FIFO_DEPTH];
	logic [sctg_pkg::FIFO_AW-1:0]      wp_q;
	logic [sctg_pkg::FIFO_AW-1:0]      rp_q;
	logic [sctg_pkg::FIFO_CW-1:0]      cnt_q;

	assign full  = cnt_q == sctg_pkg::FIFO_CW'(sctg_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + sctg_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + sctg_pkg::FIFO_AW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + sctg_pkg::FIFO_CW'(1);
				2'b01:   cnt_q <= cnt_q - sctg_pkg::FIFO_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue underflow");
`endif

endmodule

FILE: hw/rtl/sctg_back.sv
// ----------------------------------------------------------------------------
// sctg_back
// Sine pipeline: phase to table index by reciprocal multiply with one
// correction, quadrant fold, quarter-wave table read, amplitude scaling,
// sign, and the output register. All stages advance together.
// ----------------------------------------------------------------------------
module sctg_back #(
	parameter int SAMPLE_RATE = sctg_pkg::SAMPLE_RATE_DEF,
	parameter int SINE_POINTS = sctg_pkg::SINE_POINTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sctg_pkg::AMP_W-1:0]   amplitude,
	input  sctg_pkg::q_item_t            q_rdata,
	input  logic                         q_empty,
	output logic                         q_pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,   // sample[15:0], amp_enable, note_now[1:0]
	output logic                         m_tuser    // sample_valid
);

	localparam int          PW    = sctg_pkg::PHASE_W;
	localparam int          FULL  = 4 * SINE_POINTS;
	localparam logic [63:0] RECIP = (64'(FULL) << PW) / 64'(SAMPLE_RATE);
	localparam int          RW    = $clog2(RECIP + 64'd1);
	localparam int          MW    = PW + RW;
	localparam int          IW1   = $clog2(FULL + 1);
	localparam int          IW    = $clog2(FULL);
	localparam int          NW    = $clog2(FULL * SAMPLE_RATE + 1);
	localparam int          AW    = $clog2(SINE_POINTS + 1);
	localparam int          PRW   = sctg_pkg::AMP_W + sctg_pkg::MAG_W;

	logic [sctg_pkg::MAG_W-1:0] tab [0:SINE_POINTS];

	for (genvar k = 0; k <= SINE_POINTS; k++) begin : g_tab
		localparam logic [63:0] X = (sctg_pkg::PI_HALF_Q30 * 64'(k)) / 64'(SINE_POINTS);
		assign tab[k] = sctg_pkg::quarter_q15(X);
	end

	logic                       adv;
	logic                       vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	sctg_pkg::info_t            info_s1, info_s2, info_s3, info_s4, info_s5, info_s6;
	logic [MW-1:0]              prod_s1;
	logic [PW-1:0]              phase_s1;
	logic [IW1-1:0]             q0_s2;
	logic [IW1-1:0]             q1_s2;
	logic [NW-1:0]              thr_s2;
	logic [NW-1:0]              num_s2;
	logic [IW-1:0]              idx_s3;
	logic [AW-1:0]              addr_s4;
	logic                       neg_s4, neg_s5, neg_s6;
	logic [sctg_pkg::MAG_W-1:0] mag_s5;
	logic [sctg_pkg::MAG_W-1:0] amp_s6;
	logic                       tvalid_q;
	logic [23:0]                tdata_q;
	logic                       tuser_q;

	logic [IW1-1:0]             q0;
	logic [IW1-1:0]             q1;
	logic [AW-1:0]              rem;
	logic [1:0]                 quad;
	logic [PRW-1:0]             amp_prod;
	logic [15:0]                mag16;
	logic [15:0]                sample;

	assign adv   = !tvalid_q || m_tready;
	assign q_pop = adv && !q_empty;

	assign q0 = IW1'(prod_s1 >> PW);
	assign q1 = q0 + IW1'(1);

	always_comb begin
		priority if (idx_s3 >= IW'(3 * SINE_POINTS)) begin
			quad = 2'd3;
			rem  = AW'(idx_s3 - IW'(3 * SINE_POINTS));
		end else if (idx_s3 >= IW'(2 * SINE_POINTS)) begin
			quad = 2'd2;
			rem  = AW'(idx_s3 - IW'(2 * SINE_POINTS));
		end else if (idx_s3 >= IW'(SINE_POINTS)) begin
			quad = 2'd1;
			rem  = AW'(idx_s3 - IW'(SINE_POINTS));
		end else begin
			quad = 2'd0;
			rem  = AW'(idx_s3);
		end
	end

	assign amp_prod = PRW'(amplitude) * PRW'(mag_s5);
	assign mag16    = {1'b0, amp_s6};
	assign sample   = !info_s6.sv ? 16'd0 : (neg_s6 ? 16'd0 - mag16 : mag16);

	always_ff @(posedge clk) begin
		if (adv) begin
			info_s1  <= q_rdata.info;
			phase_s1 <= q_rdata.phase;
			prod_s1  <= MW'(q_rdata.phase) * MW'(RECIP);

			info_s2  <= info_s1;
			q0_s2    <= q0;
			q1_s2    <= q1;
			thr_s2   <= NW'(q1) * NW'(SAMPLE_RATE);
			num_s2   <= NW'(phase_s1) * NW'(FULL);

			info_s3  <= info_s2;
			idx_s3   <= (thr_s2 <= num_s2) ? IW'(q1_s2) : IW'(q0_s2);

			info_s4  <= info_s3;
			addr_s4  <= quad[0] ? AW'(SINE_POINTS) - rem : rem;
			neg_s4   <= quad[1];

			info_s5  <= info_s4;
			mag_s5   <= tab[addr_s4];
			neg_s5   <= neg_s4;

			info_s6  <= info_s5;
			amp_s6   <= amp_prod[PRW-1:sctg_pkg::MAG_W];
			neg_s6   <= neg_s5;

			tdata_q  <= {5'd0, info_s6.note, info_s6.amp_en, sample};
			tuser_q  <= info_s6.sv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			vld_s6   <= 1'b0;
			tvalid_q <= 1'b0;
		end else if (adv) begin
			vld_s1   <= !q_empty;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			tvalid_q <= vld_s6;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> idx_s3 < FULL) else $error("table index out of range");
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tdata[15:0] == 16'd0)
		else $error("nonzero sample on an unplayed word");
`endif

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serial controlled tone generator.
// ----------------------------------------------------------------------------
// Sends command and tick words under several idle and stall mixes and programs
// the amplitude and note registers over APB between phases, reading each one
// back. A bit-exact tone predictor follows every accepted input word, and each
// output word is checked in order against what the predictor computed. One
// phase holds the output off long enough for the input side to back up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 10;

	// unmapped register slots
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef enum logic {
		KIND_CMD  = 1'b0,
		KIND_TICK = 1'b1
	} word_kind_e;

	typedef struct packed {
		logic [15:0]                sample;
		logic                       sv;
		logic                       amp_en;
		logic [sctg_pkg::SEL_W-1:0] note;
	} tone_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [7:0]                    s_tdata;   // cmd_byte[7:0]
	logic                          s_tuser;   // kind
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [23:0]                   m_tdata;   // sample[15:0], amp_enable, note_now[1:0]
	logic                          m_tuser;   // sample_valid
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [sctg_pkg::PADDR_W-1:0]  paddr;
	logic [sctg_pkg::DATA_W-1:0]   pwdata;
	logic [sctg_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	// tone predictor state
	logic [sctg_pkg::MAG_W-1:0]  quarter_sine [0:sctg_pkg::SINE_POINTS_DEF];
	logic [sctg_pkg::AMP_W-1:0]  amp_reg;
	logic [sctg_pkg::NOTE_W-1:0] note_hz [sctg_pkg::NOTES];
	logic                        playing;
	logic [sctg_pkg::SEL_W-1:0]  note_sel;
	int unsigned                 frame_cnt;
	int unsigned                 phase_acc;

	tone_t tone_words[$];

	int mismatches    = 0;
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int hold_reqs     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	int src_mix [4] = '{0, 57, 0, 14};
	int snk_mix [4] = '{0, 0, 57, 14};

	serial_controlled_tone_generator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Q30 Taylor series of sin over the quarter wave, rounded to unsigned Q0.15
	function automatic logic [sctg_pkg::MAG_W-1:0] taylor_sine(int unsigned k);
		logic [63:0] x;
		logic [63:0] xx;
		logic [63:0] term;
		logic [63:0] acc;
		x    = (sctg_pkg::PI_HALF_Q30 * 64'(k)) / 64'(sctg_pkg::SINE_POINTS_DEF);
		xx   = (x * x) >> 30;
		term = x;
		acc  = x;
		for (int n = 1; n <= sctg_pkg::TAYLOR_TERMS; n++) begin
			term = ((term * xx) >> 30) / 64'((2 * n) * (2 * n + 1));
			acc  = (n % 2 == 1) ? acc - term : acc + term;
		end
		if (acc > sctg_pkg::Q30_ONE) begin
			acc = sctg_pkg::Q30_ONE;
		end
		return sctg_pkg::MAG_W'((acc * 64'd32767 + (sctg_pkg::Q30_ONE >> 1)) >> 30);
	endfunction

	function automatic tone_t step_tone(word_kind_e kind, logic [7:0] chr);
		tone_t       t;
		logic [63:0] idx;
		logic [1:0]  quad;
		int unsigned rem;
		logic [31:0] level;
		t = '0;
		if (kind == KIND_CMD) begin
			if (chr >= sctg_pkg::CH_NOTE_FIRST && chr <= sctg_pkg::CH_NOTE_LAST) begin
				note_sel  = sctg_pkg::SEL_W'(chr - sctg_pkg::CH_NOTE_FIRST);
				frame_cnt = 0;
				phase_acc = 0;
			end else if (chr == sctg_pkg::CH_PLAY) begin
				if (!playing) begin
					frame_cnt = 0;
					phase_acc = 0;
					playing   = 1'b1;
				end
			end else if (chr == sctg_pkg::CH_STOP) begin
				playing = 1'b0;
			end
		end else if (playing) begin
			idx   = 64'(phase_acc) * 64'(4 * sctg_pkg::SINE_POINTS_DEF)
				/ 64'(sctg_pkg::SAMPLE_RATE_DEF);
			quad  = 2'(idx / 64'(sctg_pkg::SINE_POINTS_DEF));
			rem   = int'(idx % 64'(sctg_pkg::SINE_POINTS_DEF));
			level = 32'(amp_reg) * 32'(quad[0]
				? quarter_sine[sctg_pkg::SINE_POINTS_DEF - rem] : quarter_sine[rem]);
			level = level >> 15;
			t.sample = quad[1] ? 16'(16'd0 - level[15:0]) : level[15:0];
			t.sv     = 1'b1;
			phase_acc = (phase_acc + 32'(note_hz[note_sel])) % 32'(sctg_pkg::SAMPLE_RATE_DEF);
			frame_cnt = (frame_cnt + 1) & ((1 << sctg_pkg::FRAME_W) - 1);
			if (frame_cnt >= sctg_pkg::FRAMES_DEF) begin
				frame_cnt = 0;
				phase_acc = 0;
			end
		end
		t.amp_en = playing;
		t.note   = note_sel;
		return t;
	endfunction

	task automatic log_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%s", msg);
		end
	endtask

	// output checker
	always @(posedge clk) begin : out_check
		tone_t want;
		tone_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tuser, m_tdata[16], m_tdata[18:17]};
			if (tone_words.size() == 0) begin
				log_mismatch($sformatf("unexpected word: sample %0d sv %0b amp %0b note %0d",
					$signed(got.sample), got.sv, got.amp_en, got.note));
			end else begin
				want = tone_words.pop_front();
				if (got !== want || m_tdata[23:19] !== 5'd0) begin
					log_mismatch($sformatf(
						"word mismatch: exp sample %0d sv %0b amp %0b note %0d, %s",
						$signed(want.sample), want.sv, want.amp_en, want.note,
						$sformatf("got sample %0d sv %0b amp %0b note %0d pad %h",
						$signed(got.sample), got.sv, got.amp_en, got.note,
						m_tdata[23:19])));
				end
			end
		end
	end

	// output stall generator, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_word(word_kind_e kind, logic [7:0] chr);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= chr;
		do @(posedge clk); while (!s_tready);
		tone_words.push_back(step_tone(kind, chr));
	endtask

	task automatic drain_words();
		s_tvalid <= 1'b0;
		while (tone_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, logic [sctg_pkg::DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= sctg_pkg::PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			sctg_pkg::REG_AMPLITUDE: amp_reg = sctg_pkg::AMP_W'(value);
			sctg_pkg::REG_NOTE0:     note_hz[0] = sctg_pkg::NOTE_W'(value);
			sctg_pkg::REG_NOTE1:     note_hz[1] = sctg_pkg::NOTE_W'(value);
			sctg_pkg::REG_NOTE2:     note_hz[2] = sctg_pkg::NOTE_W'(value);
			sctg_pkg::REG_NOTE3:     note_hz[3] = sctg_pkg::NOTE_W'(value);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apb_check(logic [2:0] idx);
		logic [sctg_pkg::DATA_W-1:0] want;
		case (idx)
			sctg_pkg::REG_AMPLITUDE: want = sctg_pkg::DATA_W'(amp_reg);
			sctg_pkg::REG_NOTE0:     want = sctg_pkg::DATA_W'(note_hz[0]);
			sctg_pkg::REG_NOTE1:     want = sctg_pkg::DATA_W'(note_hz[1]);
			sctg_pkg::REG_NOTE2:     want = sctg_pkg::DATA_W'(note_hz[2]);
			default:                 want = sctg_pkg::DATA_W'(note_hz[3]);
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= sctg_pkg::PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			log_mismatch($sformatf("register %0d readback: exp %0d got %0d", idx, want, prdata));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_tones(logic [sctg_pkg::DATA_W-1:0] amp,
			logic [sctg_pkg::DATA_W-1:0] n0, logic [sctg_pkg::DATA_W-1:0] n1,
			logic [sctg_pkg::DATA_W-1:0] n2, logic [sctg_pkg::DATA_W-1:0] n3);
		apb_write(sctg_pkg::REG_AMPLITUDE, amp);
		apb_write(sctg_pkg::REG_NOTE0, n0);
		apb_write(sctg_pkg::REG_NOTE1, n1);
		apb_write(sctg_pkg::REG_NOTE2, n2);
		apb_write(sctg_pkg::REG_NOTE3, n3);
		apb_check(sctg_pkg::REG_AMPLITUDE);
		apb_check(sctg_pkg::REG_NOTE0);
		apb_check(sctg_pkg::REG_NOTE1);
		apb_check(sctg_pkg::REG_NOTE2);
		apb_check(sctg_pkg::REG_NOTE3);
	endtask

	function automatic logic [sctg_pkg::DATA_W-1:0] pick_note_hz();
		case ($urandom_range(9))
			0:       return 0;
			1:       return (1 << sctg_pkg::NOTE_W) - 1;
			2:       return $urandom;
			default: return $urandom_range(8000, 1);
		endcase
	endfunction

	function automatic logic [sctg_pkg::DATA_W-1:0] pick_amplitude();
		case ($urandom_range(5))
			0:       return 0;
			1:       return (1 << sctg_pkg::AMP_W) - 1;
			default: return $urandom;
		endcase
	endfunction

	task automatic play_random(int count);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 86) begin
				send_word(KIND_TICK, 8'($urandom));
			end else if (pick < 91) begin
				send_word(KIND_CMD, sctg_pkg::CH_NOTE_FIRST + 8'($urandom_range(3)));
			end else if (pick < 94) begin
				send_word(KIND_CMD, sctg_pkg::CH_PLAY);
			end else if (pick < 96) begin
				send_word(KIND_CMD, sctg_pkg::CH_STOP);
			end else begin
				send_word(KIND_CMD, 8'($urandom));
			end
		end
	endtask

	task automatic test_commands();
		// playing at reset, note 0
		send_word(KIND_TICK, 8'h00);
		send_word(KIND_TICK, 8'hFF);
		send_word(KIND_TICK, 8'h00);
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_FIRST + 8'd1);
		send_word(KIND_TICK, 8'h00);
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_FIRST + 8'd2);
		send_word(KIND_TICK, 8'h00);
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_LAST);
		send_word(KIND_TICK, 8'h00);
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_FIRST);
		send_word(KIND_TICK, 8'h00);
		// play while playing
		send_word(KIND_CMD, sctg_pkg::CH_PLAY);
		send_word(KIND_TICK, 8'h00);
		// stop, tick while stopped, stop again, note change while stopped
		send_word(KIND_CMD, sctg_pkg::CH_STOP);
		send_word(KIND_TICK, 8'h00);
		send_word(KIND_CMD, sctg_pkg::CH_STOP);
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_FIRST + 8'd2);
		send_word(KIND_TICK, 8'h00);
		send_word(KIND_CMD, sctg_pkg::CH_PLAY);
		send_word(KIND_TICK, 8'h00);
		// ignored bytes
		send_word(KIND_CMD, 8'h00);
		send_word(KIND_CMD, 8'hFF);
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_FIRST - 8'd1);
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_LAST + 8'd1);
		send_word(KIND_TICK, 8'h00);
		drain_words();
	endtask

	task automatic test_registers();
		load_tones(32'h7FFF, 32'd8000, 32'd1, 32'd0, 32'h1FFF);
		repeat (20) send_word(KIND_TICK, 8'($urandom));
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_LAST);
		repeat (10) send_word(KIND_TICK, 8'($urandom));
		drain_words();
		// upper bits dropped, unmapped slots have no effect
		load_tones(32'hFFFF_0000, 32'hFFFF_E000 | 32'd7999, 32'hFFFF_E000 | 32'd16,
			32'hFFFF_E000 | 32'd4000, 32'hFFFF_E000 | 32'd2500);
		apb_write(REG_SPARE_LO, '1);
		apb_write(REG_SPARE_HI, '1);
		apb_check(sctg_pkg::REG_AMPLITUDE);
		apb_check(sctg_pkg::REG_NOTE3);
		repeat (10) send_word(KIND_TICK, 8'($urandom));
		drain_words();
	endtask

	task automatic test_frame_wrap();
		src_idle_pct  = src_mix[3];
		snk_stall_pct = snk_mix[3];
		load_tones(32'd20000, 32'd397, 32'd1234, 32'd7919, 32'd8191);
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_FIRST + 8'd1);
		repeat (330) send_word(KIND_TICK, 8'($urandom));
		send_word(KIND_CMD, sctg_pkg::CH_NOTE_LAST);
		repeat (330) send_word(KIND_TICK, 8'($urandom));
		drain_words();
	endtask

	task automatic test_output_hold();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_reqs     = hold_reqs + 1;
		repeat (60) send_word(KIND_TICK, 8'($urandom));
		drain_words();
	endtask

	task automatic test_random_traffic();
		for (int mode = 0; mode < 4; mode++) begin
			src_idle_pct  = src_mix[mode];
			snk_stall_pct = snk_mix[mode];
			for (int seg = 0; seg < 2; seg++) begin
				load_tones(pick_amplitude(), pick_note_hz(), pick_note_hz(),
					pick_note_hz(), pick_note_hz());
				play_random(50);
				drain_words();
			end
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		for (int k = 0; k <= sctg_pkg::SINE_POINTS_DEF; k++) begin
			quarter_sine[k] = taylor_sine(k);
		end
		amp_reg    = sctg_pkg::AMP_RST;
		note_hz[0] = sctg_pkg::NOTE0_RST;
		note_hz[1] = sctg_pkg::NOTE1_RST;
		note_hz[2] = sctg_pkg::NOTE2_RST;
		note_hz[3] = sctg_pkg::NOTE3_RST;
		playing    = 1'b1;
		note_sel   = '0;
		frame_cnt  = 0;
		phase_acc  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_commands();
		test_registers();
		test_frame_wrap();
		test_output_hold();
		test_random_traffic();
		drain_words();
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
